/* rtl/core/kcl_pkg.sv */
package kcl_pkg;

  // digit layout of the code registers
  localparam int unsigned DigitW     = 2;
  localparam int unsigned CodeW      = 6;
  localparam int unsigned CodeDigits = CodeW / DigitW;
  localparam int unsigned TickW      = 8;

  // default code length in digits
  localparam int unsigned CodeDigitsDefault = 3;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_USER_CODE      = 3'd0,
    CFG_MASTER_CODE    = 3'd1,
    CFG_UNLOCK_TICKS   = 3'd2,
    CFG_WARNING_TICKS  = 3'd3,
    CFG_LOCKDOWN_TICKS = 3'd4
  } cfg_idx_e;

  // reset values of the configuration registers
  localparam logic [CodeW-1:0] UserCodeRst      = 6'd57;
  localparam logic [CodeW-1:0] MasterCodeRst    = 6'd0;
  localparam logic [TickW-1:0] UnlockTicksRst   = 8'd10;
  localparam logic [TickW-1:0] WarningTicksRst  = 8'd20;
  localparam logic [TickW-1:0] LockdownTicksRst = 8'd240;

  localparam int unsigned StatusW = 3;

  typedef enum logic [StatusW-1:0] {
    ST_NONE          = 3'd0,
    ST_KEY_TAKEN     = 3'd1,
    ST_GRANTED       = 3'd2,
    ST_DENIED        = 3'd3,
    ST_ADMIN_CLEARED = 3'd4,
    ST_ADMIN_WRONG   = 3'd5,
    ST_LOCK_EXPIRED  = 3'd6
  } status_e;

endpackage

/* rtl/core/keypad_code_lock_with_lockout.sv */
// result: the result beat of an accepted input beat is registered and valid in the next cycle
// throughput: one beat per cycle while the sink keeps up; the lock state and the result
//   register update together on each accepted beat; a waiting result is replaced when taken
// reset: asynchronous, active low; entry mode, red lamp on, counts and timers cleared,
//   configuration registers back to their defaults (user code 57, master code 0, 10/20/240)
module keypad_code_lock_with_lockout #(
  parameter int unsigned CODE_DIGITS = kcl_pkg::CodeDigitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [kcl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kcl_pkg::CfgDataW-1:0] cfg_data_i,
  // event input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic [1:0]                   key_value_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         led_green_o,
  output logic                         led_red_o,
  output logic                         led_blue_o,
  output logic [kcl_pkg::StatusW-1:0]  status_o
);

  localparam int unsigned DigW  = kcl_pkg::DigitW;
  localparam int unsigned TypW  = DigW * CODE_DIGITS;
  localparam int unsigned CntW  = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int unsigned TickW = kcl_pkg::TickW;

  typedef enum logic [1:0] {
    MODE_ENTRY    = 2'd0,
    MODE_UNLOCKED = 2'd1,
    MODE_WARNING  = 2'd2,
    MODE_LOCKDOWN = 2'd3
  } mode_e;

  // configuration registers
  logic [kcl_pkg::CodeW-1:0] user_code_q, master_code_q;
  logic [TickW-1:0]          unlock_ticks_q, warning_ticks_q, lockdown_ticks_q;

  // lock state
  mode_e            mode_q, mode_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [TypW-1:0]  typed_q, typed_d;
  logic [1:0]       fail_q, fail_d;
  logic             after_warn_q, after_warn_d;
  logic [TickW-1:0] timer_q, timer_d;
  logic             red_q, red_d;

  // result register
  logic                       out_valid_q;
  logic                       green_q, blue_q;
  kcl_pkg::status_e           status_q, status_d;

  logic accept;

  // a new beat may enter whenever the result slot is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // codes widened to the typed length; digits beyond the register read as zero
  logic [TypW-1:0] user_vec, master_vec;
  always_comb begin
    user_vec   = '0;
    master_vec = '0;
    for (int unsigned i = 0; i < CODE_DIGITS; i++) begin
      if (i < kcl_pkg::CodeDigits) begin
        user_vec[DigW*i +: DigW]   = user_code_q[DigW*i +: DigW];
        master_vec[DigW*i +: DigW] = master_code_q[DigW*i +: DigW];
      end
    end
  end

  // digit entry shared by entry mode and lockdown
  logic [TypW-1:0] typed_new;
  logic            code_done;
  always_comb begin
    typed_new = typed_q;
    for (int unsigned i = 0; i < CODE_DIGITS; i++) begin
      if (cnt_q == CntW'(i)) begin
        typed_new[DigW*i +: DigW] = key_value_i;
      end
    end
  end
  assign code_done = (cnt_q == CntW'(CODE_DIGITS - 1));

  // next fail count on a miss: a miss right after a warning goes straight to lockdown
  logic [1:0] fail_miss;
  assign fail_miss = (after_warn_q || fail_q == 2'd3) ? 2'd3 : fail_q + 2'd1;

  // shared tick handling for the timed phases (unlocked, warning and lockdown)
  logic             phase_end;
  logic [TickW-1:0] timer_dec;
  assign phase_end = (timer_q <= TickW'(1));
  assign timer_dec = timer_q - TickW'(1);

  always_comb begin
    mode_d       = mode_q;
    cnt_d        = cnt_q;
    typed_d      = typed_q;
    fail_d       = fail_q;
    after_warn_d = after_warn_q;
    timer_d      = timer_q;
    red_d        = red_q;
    status_d     = kcl_pkg::ST_NONE;

    unique case (mode_q)
      MODE_ENTRY: begin
        if (!cmd_i) begin
          status_d = kcl_pkg::ST_KEY_TAKEN;
          if (code_done) begin
            cnt_d   = '0;
            typed_d = '0;
            if (typed_new == user_vec) begin
              fail_d       = 2'd0;
              after_warn_d = 1'b0;
              red_d        = 1'b0;
              timer_d      = unlock_ticks_q;
              mode_d       = MODE_UNLOCKED;
              status_d     = kcl_pkg::ST_GRANTED;
            end else begin
              fail_d       = fail_miss;
              after_warn_d = 1'b0;
              status_d     = kcl_pkg::ST_DENIED;
              if (fail_miss == 2'd2) begin
                red_d   = !red_q;
                timer_d = warning_ticks_q;
                mode_d  = MODE_WARNING;
              end else if (fail_miss == 2'd3) begin
                red_d   = !red_q;
                timer_d = lockdown_ticks_q;
                mode_d  = MODE_LOCKDOWN;
              end
            end
          end else begin
            cnt_d   = cnt_q + CntW'(1);
            typed_d = typed_new;
          end
        end
      end
      MODE_UNLOCKED: begin
        if (cmd_i) begin
          if (phase_end) begin
            timer_d = '0;
            red_d   = 1'b1;
            mode_d  = MODE_ENTRY;
          end else begin
            timer_d = timer_dec;
          end
        end
      end
      MODE_WARNING: begin
        if (cmd_i) begin
          if (phase_end) begin
            timer_d      = '0;
            red_d        = 1'b1;
            after_warn_d = 1'b1;
            mode_d       = MODE_ENTRY;
          end else begin
            timer_d = timer_dec;
            if (!timer_dec[0]) red_d = !red_q;
          end
        end
      end
      MODE_LOCKDOWN: begin
        if (!cmd_i) begin
          status_d = kcl_pkg::ST_KEY_TAKEN;
          if (code_done) begin
            cnt_d   = '0;
            typed_d = '0;
            if (typed_new == master_vec) begin
              fail_d       = 2'd0;
              after_warn_d = 1'b0;
              timer_d      = '0;
              red_d        = 1'b1;
              mode_d       = MODE_ENTRY;
              status_d     = kcl_pkg::ST_ADMIN_CLEARED;
            end else begin
              status_d = kcl_pkg::ST_ADMIN_WRONG;
            end
          end else begin
            cnt_d   = cnt_q + CntW'(1);
            typed_d = typed_new;
          end
        end else if (cnt_q == '0) begin
          // timer frozen while a master code is partly typed
          if (phase_end) begin
            timer_d      = '0;
            red_d        = 1'b1;
            after_warn_d = 1'b0;
            mode_d       = MODE_ENTRY;
            status_d     = kcl_pkg::ST_LOCK_EXPIRED;
          end else begin
            timer_d = timer_dec;
            if (!timer_dec[0]) red_d = !red_q;
          end
        end
      end
      default: ;
    endcase
  end

  // configuration, lock state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_code_q      <= kcl_pkg::UserCodeRst;
      master_code_q    <= kcl_pkg::MasterCodeRst;
      unlock_ticks_q   <= kcl_pkg::UnlockTicksRst;
      warning_ticks_q  <= kcl_pkg::WarningTicksRst;
      lockdown_ticks_q <= kcl_pkg::LockdownTicksRst;
      mode_q           <= MODE_ENTRY;
      cnt_q            <= '0;
      typed_q          <= '0;
      fail_q           <= 2'd0;
      after_warn_q     <= 1'b0;
      timer_q          <= '0;
      red_q            <= 1'b1;
      out_valid_q      <= 1'b0;
      green_q          <= 1'b0;
      blue_q           <= 1'b0;
      status_q         <= kcl_pkg::ST_NONE;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          kcl_pkg::CFG_USER_CODE:      user_code_q      <= cfg_data_i[kcl_pkg::CodeW-1:0];
          kcl_pkg::CFG_MASTER_CODE:    master_code_q    <= cfg_data_i[kcl_pkg::CodeW-1:0];
          kcl_pkg::CFG_UNLOCK_TICKS:   unlock_ticks_q   <= cfg_data_i[TickW-1:0];
          kcl_pkg::CFG_WARNING_TICKS:  warning_ticks_q  <= cfg_data_i[TickW-1:0];
          kcl_pkg::CFG_LOCKDOWN_TICKS: lockdown_ticks_q <= cfg_data_i[TickW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        mode_q       <= mode_d;
        cnt_q        <= cnt_d;
        typed_q      <= typed_d;
        fail_q       <= fail_d;
        after_warn_q <= after_warn_d;
        timer_q      <= timer_d;
        red_q        <= red_d;
        out_valid_q  <= 1'b1;
        green_q      <= (mode_d == MODE_UNLOCKED);
        blue_q       <= (mode_d == MODE_LOCKDOWN);
        status_q     <= status_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_green_o = green_q;
  assign led_red_o   = red_q;
  assign led_blue_o  = blue_q;
  assign status_o    = status_q;

  // the red lamp is steady on whenever codes are being entered
  a_entry_red_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_ENTRY |-> red_q)
    else $error("red lamp off in entry mode");

  // unlocked means red off
  a_unlocked_red_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_UNLOCKED |-> !red_q)
    else $error("red lamp on while unlocked");

  // warning only after exactly two misses
  a_warning_fail_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_WARNING |-> fail_q == 2'd2)
    else $error("warning without two misses");

  // lockdown only with a saturated fail count
  a_lockdown_fail_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_LOCKDOWN |-> fail_q == 2'd3)
    else $error("lockdown without three misses");

  // a granted beat must show green and not blue
  a_granted_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == kcl_pkg::ST_GRANTED |-> green_q && !blue_q)
    else $error("granted result without green lamp");

endmodule
